// File: rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_parser and websocket_frame_deframer; depends on nothing.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_result;

endpackage

// File: rtl/core/wsd_parser.sv
// Frame header parser and payload unmasker: holds the parse state and works out
// the result for one stream byte per cycle while i_step is high. Depends on wsd_pkg.
module wsd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output wsd_pkg::t_result  o_res
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_op, n_op;
    logic        r_masked, n_masked;
    logic [3:0]  r_ext, n_ext;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_mbi, n_mbi;
    logic [2:0]  r_mbl, n_mbl;

    logic        len_known;
    logic        hdr_done;
    logic        pay_last;
    logic [7:0]  key_byte;
    logic [7:0]  pay_value;

    always_comb begin
        case (r_mbi)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign pay_value = r_masked ? (i_byte ^ key_byte) : i_byte;

    // Next-state logic.
    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_masked  = r_masked;
        n_ext     = r_ext;
        n_rem     = r_rem;
        n_key     = r_key;
        n_mbi     = r_mbi;
        n_mbl     = r_mbl;
        len_known = 1'b0;
        hdr_done  = 1'b0;
        pay_last  = 1'b0;
        case (r_phase)
            wsd_pkg::PH_HDR1: begin
                n_masked = i_byte[7];
                n_rem    = 64'd0;
                if (i_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                    n_ext   = wsd_pkg::EXT16_BYTES;
                    n_phase = wsd_pkg::PH_EXTLEN;
                end else if (i_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                    n_ext   = wsd_pkg::EXT64_BYTES;
                    n_phase = wsd_pkg::PH_EXTLEN;
                end else begin
                    n_rem     = {57'd0, i_byte[6:0]};
                    len_known = 1'b1;
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                n_rem = {r_rem[55:0], i_byte};
                n_ext = r_ext - 4'd1;
                if (n_ext == 4'd0) begin
                    len_known = 1'b1;
                end
            end
            wsd_pkg::PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                n_mbl = r_mbl - 3'd1;
                if (n_mbl == 3'd0) begin
                    hdr_done = 1'b1;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                n_mbi    = r_mbi + 2'd1;
                n_rem    = r_rem - 64'd1;
                pay_last = (n_rem == 64'd0);
                if (pay_last) begin
                    n_phase = (r_op == wsd_pkg::OP_CLOSE) ? wsd_pkg::PH_CLOSED
                                                          : wsd_pkg::PH_HDR0;
                end
            end
            wsd_pkg::PH_CLOSED: begin
            end
            default: begin
                n_op    = i_byte[3:0];
                n_phase = wsd_pkg::PH_HDR1;
            end
        endcase

        // Once the length is known, a masked frame still has its key to collect.
        if (len_known) begin
            if (n_masked) begin
                n_key   = 32'd0;
                n_mbl   = wsd_pkg::KEY_BYTES;
                n_phase = wsd_pkg::PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_mbi = 2'd0;
            if (n_rem != 64'd0) begin
                n_phase = wsd_pkg::PH_PAYLOAD;
            end else if (r_op == wsd_pkg::OP_CLOSE) begin
                n_phase = wsd_pkg::PH_CLOSED;
            end else begin
                n_phase = wsd_pkg::PH_HDR0;
            end
        end
    end

    // Result logic.
    always_comb begin
        o_res = '0;
        if (r_phase == wsd_pkg::PH_PAYLOAD) begin
            if (r_op == wsd_pkg::OP_TEXT) begin
                o_res.valid         = 1'b1;
                o_res.kind          = wsd_pkg::KIND_BYTE;
                o_res.payload_byte  = pay_value;
                o_res.last_of_frame = pay_last;
            end else if (r_op == wsd_pkg::OP_CLOSE && pay_last) begin
                o_res.valid         = 1'b1;
                o_res.kind          = wsd_pkg::KIND_CLOSE;
                o_res.last_of_frame = 1'b1;
            end
        end else if (hdr_done && n_rem == 64'd0) begin
            if (r_op == wsd_pkg::OP_CLOSE) begin
                o_res.valid         = 1'b1;
                o_res.kind          = wsd_pkg::KIND_CLOSE;
                o_res.last_of_frame = 1'b1;
            end else if (r_op == wsd_pkg::OP_TEXT) begin
                o_res.valid         = 1'b1;
                o_res.kind          = wsd_pkg::KIND_EMPTY;
                o_res.last_of_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR0;
            r_op     <= 4'd0;
            r_masked <= 1'b0;
            r_ext    <= 4'd0;
            r_rem    <= 64'd0;
            r_key    <= 32'd0;
            r_mbi    <= 2'd0;
            r_mbl    <= 3'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_masked <= n_masked;
            r_ext    <= n_ext;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_mbi    <= n_mbi;
            r_mbl    <= n_mbl;
        end
    end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// WebSocket receive deframer top level: input register, parser and result register.
// Depends on wsd_pkg and wsd_parser.
//
// Usage: raw stream bytes enter on the s_axis channel, one byte per request.
// Text frame payload bytes leave on the m_axis channel unmasked, with tuser
// giving the kind (payload byte, empty text frame, close seen) and tlast
// marking the final result of a frame. Header bytes and payloads of other
// opcodes give no result. After a close frame every byte is taken and dropped
// until reset.
// Path: a byte is caught in the input register at acceptance, then one pass
// through the parser fills the result register, which drives m_axis; a
// receiver stall can hold the byte in the input register before that pass.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// parser step with its 64-bit length decrement and zero compare.
// Reset (synchronous, active low) returns the parser to the first header byte
// and empties both registers. When the receiver stalls, the result register
// holds, the held byte waits in the input register, and s_axis tready falls
// only once both are full.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] kind
    output logic       o_m_axis_tlast    // last_of_frame
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic [1:0]       r_out_kind;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             advance;
    logic             step;
    wsd_pkg::t_result res;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid && advance) begin
            r_out_kind <= res.kind;
            r_out_byte <= res.payload_byte;
            r_out_last <= res.last_of_frame;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: verif/websocket_frame_deframer_tb.sv
// Self-checking testbench for websocket_frame_deframer: streams framed bytes in,
// predicts the deframed results and checks each one as it leaves the block.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 12;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } ws_result_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = '0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    websocket_frame_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [7:0] stream_bytes[$];
    ws_result_t deframed_q[$];
    int         bytes_queued   = 0;
    int         bytes_accepted = 0;
    int         frames_queued  = 0;
    int         results_seen   = 0;
    int         failures       = 0;
    int         quiet_cycles   = 0;
    int         kind_tally[4]  = '{0, 0, 0, 0};
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    // Shadow copy of the parser state.
    t_phase      rx_phase       = PH_HDR0;
    logic [3:0]  rx_opcode      = '0;
    logic        rx_masked      = 1'b0;
    logic [3:0]  len_bytes_left = '0;
    logic [63:0] bytes_to_go    = '0;
    logic [31:0] key_word       = '0;
    logic [1:0]  key_pos        = '0;
    logic [2:0]  key_bytes_left = '0;

    function automatic void expect_result(logic [1:0] kind, logic [7:0] data, logic last);
        ws_result_t r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        deframed_q.push_back(r);
    endfunction

    // Header and key complete: either enter the payload or finish an empty frame.
    function automatic void finish_header();
        key_pos = '0;
        if (bytes_to_go != 0) begin
            rx_phase = PH_PAYLOAD;
        end else if (rx_opcode == OP_CLOSE) begin
            rx_phase = PH_CLOSED;
            expect_result(KIND_CLOSE, 8'h00, 1'b1);
        end else begin
            rx_phase = PH_HDR0;
            if (rx_opcode == OP_TEXT)
                expect_result(KIND_EMPTY, 8'h00, 1'b1);
        end
    endfunction

    function automatic void finish_length();
        if (rx_masked) begin
            key_word       = '0;
            key_bytes_left = KEY_BYTES;
            rx_phase       = PH_MASK;
        end else begin
            finish_header();
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [7:0] v;
        logic       fin;
        case (rx_phase)
            PH_HDR1: begin
                rx_masked   = b[7];
                bytes_to_go = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    len_bytes_left = EXT16_BYTES;
                    rx_phase       = PH_EXTLEN;
                end else if (b[6:0] == LEN7_EXT64) begin
                    len_bytes_left = EXT64_BYTES;
                    rx_phase       = PH_EXTLEN;
                end else begin
                    bytes_to_go = {57'd0, b[6:0]};
                    finish_length();
                end
            end
            PH_EXTLEN: begin
                bytes_to_go    = {bytes_to_go[55:0], b};
                len_bytes_left = len_bytes_left - 4'd1;
                if (len_bytes_left == 0)
                    finish_length();
            end
            PH_MASK: begin
                key_word       = {key_word[23:0], b};
                key_bytes_left = key_bytes_left - 3'd1;
                if (key_bytes_left == 0)
                    finish_header();
            end
            PH_PAYLOAD: begin
                v = b;
                // The first key byte sits in the top of the word.
                if (rx_masked)
                    v = v ^ key_word[8 * (3 - int'(key_pos)) +: 8];
                key_pos     = key_pos + 2'd1;
                bytes_to_go = bytes_to_go - 64'd1;
                fin         = (bytes_to_go == 0);
                if (fin)
                    rx_phase = (rx_opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
                if (rx_opcode == OP_TEXT)
                    expect_result(KIND_BYTE, v, fin);
                else if (rx_opcode == OP_CLOSE && fin)
                    expect_result(KIND_CLOSE, 8'h00, 1'b1);
            end
            PH_CLOSED: begin
            end
            default: begin
                rx_opcode = b[3:0];
                rx_phase  = PH_HDR1;
            end
        endcase
    endfunction

    function automatic void send_byte(logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // enc: 0 seven-bit length, 1 sixteen-bit extension, 2 sixty-four-bit extension.
    function automatic void queue_frame(logic [7:0] hdr0, logic masked, int len, int enc,
                                        logic [31:0] key);
        logic [63:0] len64;
        len64 = 64'(len);
        frames_queued++;
        send_byte(hdr0);
        case (enc)
            0: send_byte({masked, len64[6:0]});
            1: begin
                send_byte({masked, LEN7_EXT16});
                send_byte(len64[15:8]);
                send_byte(len64[7:0]);
            end
            default: begin
                send_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len64[8 * i +: 8]);
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        end
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
    endfunction

    function automatic void queue_random_traffic(int n_bytes);
        int         target;
        int         sel;
        int         len;
        int         enc;
        logic [3:0] op;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            // Close frames are kept back for the end, since they stop the parser.
            if ($urandom_range(1) == 1) begin
                op = OP_TEXT;
            end else begin
                op = 4'($urandom_range(15));
                if (op == OP_CLOSE)
                    op = 4'h0;
            end
            sel = $urandom_range(99);
            if (sel < 10)
                len = 0;
            else if (sel < 75)
                len = $urandom_range(20, 1);
            else if (sel < 94)
                len = $urandom_range(125, 21);
            else
                len = $urandom_range(300, 126);
            if (len > 125) begin
                enc = $urandom_range(2, 1);
            end else begin
                sel = $urandom_range(9);
                enc = (sel < 7) ? 0 : (sel < 9) ? 1 : 2;
            end
            queue_frame({4'($urandom_range(15)), op}, 1'($urandom_range(1)), len, enc,
                        32'($urandom));
        end
    endfunction

    task automatic drain();
        while (bytes_accepted != bytes_queued || deframed_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: one byte per request, idling at random between requests.
    always @(posedge i_clk) begin
        logic took;
        logic stall;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            took = i_s_axis_tvalid && o_s_axis_tready;
            if (took) begin
                deframe_byte(i_s_axis_tdata);
                bytes_accepted++;
            end
            if (took || !i_s_axis_tvalid) begin
                stall = ($urandom_range(99) < send_idle_pct);
                if (!stall && stream_bytes.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= stream_bytes.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, result checking and the watchdog.
    always @(posedge i_clk) begin
        ws_result_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                kind_tally[o_m_axis_tuser]++;
                if (deframed_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: kind %0d byte %02h last %0b",
                                 o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    want = deframed_q.pop_front();
                    if (o_m_axis_tuser !== want.kind || o_m_axis_tdata !== want.data ||
                        o_m_axis_tlast !== want.last) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("result %0d mismatch: expected kind %0d byte %02h last %0b",
                                     results_seen, want.kind, want.data, want.last);
                            $display("    got kind %0d byte %02h last %0b",
                                     o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                        end
                    end
                end
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("websocket_frame_deframer regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] directed[$];
        directed = '{
            8'h81, 8'h00,                                       // empty text frame
            8'h71, 8'h02, 8'hFF, 8'h00,                         // FIN clear, reserved bits set
            8'h81, 8'h85, 8'h37, 8'hFA, 8'h21, 8'h3D,           // masked text, index wraps
            8'h7F, 8'h9F, 8'h4D, 8'h51, 8'h58,
            8'h89, 8'h00,                                       // empty ping, no result
            8'h82, 8'h7E, 8'h00, 8'h01, 8'hAB                   // binary, non-minimal length
        };
        repeat (9) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct <= 29;
        recv_idle_pct <= 78;
        foreach (directed[i])
            send_byte(directed[i]);
        frames_queued += 5;
        drain();

        // Between segments the sender holds off until every result has come back.
        queue_random_traffic(350);
        drain();
        send_idle_pct <= 78;
        recv_idle_pct <= 29;
        queue_random_traffic(350);
        drain();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random_traffic(330);
        drain();

        // A masked close frame, then bytes that must be dropped, a text header among them.
        queue_frame({4'h8, OP_CLOSE}, 1'b1, 2, 0, 32'($urandom));
        send_byte(8'h81);
        send_byte(8'h00);
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom_range(255)));
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (deframed_q.size() != 0) begin
            $display("%0d expected results never arrived", deframed_q.size());
            failures += deframed_q.size();
        end
        $display("Streamed %0d bytes in %0d frames under three back-pressure mixes.",
                 bytes_accepted, frames_queued);
        $display("Checked %0d results: %0d text bytes, %0d empty text frames, %0d close.",
                 results_seen, kind_tally[KIND_BYTE], kind_tally[KIND_EMPTY],
                 kind_tally[KIND_CLOSE]);
        if (failures == 0)
            $display("websocket_frame_deframer regression: pass");
        else
            $display("websocket_frame_deframer regression: fail");
        $finish;
    end

endmodule
